FILE: rtl/psu_pkg.sv
// Shared types, widths and constants of the Phong shading pipeline.
// No dependencies; every rtl module imports this package.
package psu_pkg;

  // Component and fraction formats
  localparam int COMP_BITS = 16;
  localparam int CFRAC     = COMP_BITS - 2;
  localparam int WF        = 16;
  localparam int UP        = WF - CFRAC;
  localparam int FIELD_W   = 3 * COMP_BITS;

  // Internal widths
  localparam int V_W     = COMP_BITS + UP;      // vector component in Q.16
  localparam int COL_W   = COMP_BITS + UP;      // colour channel in Q.16
  localparam int NL_W    = 2 * COMP_BITS + 2;   // full-precision dot product
  localparam int NL16_W  = 21;                  // N.L rescaled to Q.16
  localparam int P2_W    = NL16_W + V_W;        // nl16 * n16
  localparam int R_W     = 24;                  // reflected vector component
  localparam int RR_W    = 48;                  // |R|^2
  localparam int VR_W    = 43;                  // V.R when positive
  localparam int VRS_W   = 44;                  // signed V.R
  localparam int MAG_W   = RR_W / 2;            // |R|
  localparam int Q_W     = 17;                  // cosine quotient bits
  localparam int POW_TABLE_BITS = 8;
  localparam int LOGB    = POW_TABLE_BITS + 8;
  localparam int M_W     = 31;                  // log mantissa in Q.30
  localparam int K_W     = 5;
  localparam int NEG_W   = K_W + LOGB;
  localparam int POW_W   = 17;
  localparam int SPEC_W  = 19;
  localparam int DIFF_W  = 22;
  localparam int OUT_W   = 16;

  // N.L > 0.0001 in Q.28 is N.L > this bound
  localparam int EPS_NL  = (1 << (2 * CFRAC)) / 10000;
  localparam int CS_MIN  = 7;
  localparam int CS_ONE  = 1 << WF;

  typedef enum logic [2:0] {
    CFG_AMBIENT  = 3'd0,
    CFG_DIFFUSE  = 3'd1,
    CFG_SPECULAR = 3'd2,
    CFG_HARDNESS = 3'd3,
    CFG_TRANSMIT = 3'd4
  } cfg_idx_e;

  // Data that rides alongside the specular datapath
  typedef struct packed {
    logic [2:0][COL_W-1:0] obj;
    logic [2:0][COL_W-1:0] lc;
    logic                  front;
    logic [DIFF_W-1:0]     diff;
    logic                  spec_ok;
    logic [VR_W-1:0]       vr;
  } side_t;

  // Factor 2^(-2^-step) in Q.30 by repeated integer square roots
  function automatic logic [29:0] exp_root(input int unsigned step);
    longint unsigned r;
    longint unsigned x;
    longint unsigned res;
    longint unsigned bitv;
    r = 0;
    for (int unsigned j = 1; j <= step; j++) begin
      x = (j == 1) ? (64'd1 << 59) : (r << 30);
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        bitv = 64'd1 << (2 * b);
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
      end
      r = res;
    end
    return r[29:0];
  endfunction

endpackage

FILE: rtl/psu_geom.sv
// Front end of the shading pipeline: dot products, face test, diffuse factor,
// reflected vector, |R|^2 and V.R over five stages. Depends on psu_pkg.
module psu_geom (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [psu_pkg::FIELD_W-1:0]     ray_i,
  input  logic [psu_pkg::FIELD_W-1:0]     nrm_i,
  input  logic [psu_pkg::FIELD_W-1:0]     lgt_i,
  input  logic [psu_pkg::FIELD_W-1:0]     view_i,
  input  logic [psu_pkg::FIELD_W-1:0]     obj_i,
  input  logic [psu_pkg::FIELD_W-1:0]     lc_i,
  input  logic [15:0]                     diffuse_gain_i,
  input  logic                            full_transmission_i,
  output logic                            valid_o,
  output logic [psu_pkg::RR_W-1:0]        rr_o,
  output psu_pkg::side_t                  side_o
);
  import psu_pkg::*;

  localparam logic signed [NL_W-1:0] EPS_LIM = NL_W'(EPS_NL);

  // Stage 1: full-precision dot products
  logic signed [2*COMP_BITS-1:0] pnl [3];
  logic signed [2*COMP_BITS-1:0] prn [3];
  logic signed [NL_W-1:0]        nl_d, rn_d;
  side_t                         side1_d;

  always_comb begin
    side1_d = '0;
    for (int i = 0; i < 3; i++) begin
      pnl[i] = $signed(nrm_i[COMP_BITS*i +: COMP_BITS]) *
               $signed(lgt_i[COMP_BITS*i +: COMP_BITS]);
      prn[i] = $signed(ray_i[COMP_BITS*i +: COMP_BITS]) *
               $signed(nrm_i[COMP_BITS*i +: COMP_BITS]);
      side1_d.obj[i] = {obj_i[COMP_BITS*i +: COMP_BITS], {UP{1'b0}}};
      side1_d.lc[i]  = {lc_i[COMP_BITS*i +: COMP_BITS], {UP{1'b0}}};
    end
    nl_d = NL_W'(pnl[0]) + NL_W'(pnl[1]) + NL_W'(pnl[2]);
    rn_d = NL_W'(prn[0]) + NL_W'(prn[1]) + NL_W'(prn[2]);
    side1_d.front = rn_d[NL_W-1];
  end

  logic                   v1_q;
  logic signed [NL_W-1:0] nl1_q;
  logic signed [V_W-1:0]  n1_q [3];
  logic signed [V_W-1:0]  l1_q [3];
  logic signed [V_W-1:0]  w1_q [3];
  side_t                  side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nl1_q   <= nl_d;
      side1_q <= side1_d;
      for (int i = 0; i < 3; i++) begin
        n1_q[i] <= {nrm_i[COMP_BITS*i +: COMP_BITS], {UP{1'b0}}};
        l1_q[i] <= {lgt_i[COMP_BITS*i +: COMP_BITS], {UP{1'b0}}};
        w1_q[i] <= {view_i[COMP_BITS*i +: COMP_BITS], {UP{1'b0}}};
      end
    end
  end

  // Stage 2: N.L to Q.16, gates, diffuse factor, nl16 * n16
  logic [NL_W-1:0]          nl_mag;
  logic [NL16_W-2:0]        nl16_mag;
  logic signed [NL16_W-1:0] nl16;
  logic                     gate;
  logic [2*18-1+2:0]        diff_full;
  logic signed [P2_W-1:0]   p2_d [3];
  side_t                    side2_d;

  always_comb begin
    nl_mag   = nl1_q[NL_W-1] ? NL_W'(-nl1_q) : NL_W'(nl1_q);
    nl16_mag = nl_mag[NL16_W-2+12:12];
    nl16     = nl1_q[NL_W-1] ? -$signed({1'b0, nl16_mag}) : $signed({1'b0, nl16_mag});
    gate     = side1_q.front && (diffuse_gain_i != '0) && (nl1_q > EPS_LIM);
    diff_full = {diffuse_gain_i, 2'b00} * nl16_mag;
    for (int i = 0; i < 3; i++) begin
      p2_d[i] = nl16 * n1_q[i];
    end
    side2_d         = side1_q;
    side2_d.diff    = gate ? diff_full[DIFF_W+15:16] : '0;
    side2_d.spec_ok = side1_q.front ? gate : full_transmission_i;
  end

  logic                   v2_q;
  logic signed [P2_W-1:0] p2_q [3];
  logic signed [V_W-1:0]  l2_q [3];
  logic signed [V_W-1:0]  w2_q [3];
  side_t                  side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q    <= p2_d;
      l2_q    <= l1_q;
      w2_q    <= w1_q;
      side2_q <= side2_d;
    end
  end

  // Stage 3: R = trunc(2 nl16 n16 / 2^16) - l16
  logic signed [P2_W:0]  dbl [3];
  logic [P2_W:0]         dmag [3];
  logic signed [R_W-1:0] rt [3];
  logic signed [R_W-1:0] r3_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dbl[i]  = {p2_q[i], 1'b0};
      dmag[i] = dbl[i][P2_W] ? (P2_W+1)'(-dbl[i]) : (P2_W+1)'(dbl[i]);
      rt[i]   = dbl[i][P2_W] ? -$signed(R_W'(dmag[i] >> 16)) : $signed(R_W'(dmag[i] >> 16));
      r3_d[i] = rt[i] - $signed({{(R_W-V_W){l2_q[i][V_W-1]}}, l2_q[i]});
    end
  end

  logic                  v3_q;
  logic signed [R_W-1:0] r3_q [3];
  logic signed [V_W-1:0] w3_q [3];
  side_t                 side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r3_q    <= r3_d;
      w3_q    <= w2_q;
      side3_q <= side2_q;
    end
  end

  // Stage 4: squares of R and products with V
  logic                      v4_q;
  logic signed [2*R_W-1:0]   sq4_q [3];
  logic signed [R_W+V_W-1:0] vp4_q [3];
  side_t                     side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= r3_q[i] * r3_q[i];
        vp4_q[i] <= r3_q[i] * w3_q[i];
      end
      side4_q <= side3_q;
    end
  end

  // Stage 5: sum to |R|^2 and V.R, drop the specular term on zero R or V.R <= 0
  logic [RR_W-1:0]         rr_d;
  logic signed [VRS_W-1:0] vr_d;
  side_t                   side5_d;

  always_comb begin
    rr_d = RR_W'(sq4_q[0]) + RR_W'(sq4_q[1]) + RR_W'(sq4_q[2]);
    vr_d = VRS_W'(vp4_q[0]) + VRS_W'(vp4_q[1]) + VRS_W'(vp4_q[2]);
    side5_d         = side4_q;
    side5_d.spec_ok = side4_q.spec_ok && (rr_d != '0) && (vr_d > 0);
    side5_d.vr      = vr_d[VR_W-1:0];
  end

  logic            v5_q;
  logic [RR_W-1:0] rr5_q;
  side_t           side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr5_q   <= rr_d;
      side5_q <= side5_d;
    end
  end

  assign valid_o = v5_q;
  assign rr_o    = rr5_q;
  assign side_o  = side5_q;

endmodule

FILE: rtl/psu_isqrt.sv
// Pipelined integer square root of |R|^2, one result bit per stage.
// Depends on psu_pkg.
module psu_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [psu_pkg::RR_W-1:0]  rr_i,
  input  psu_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [psu_pkg::MAG_W-1:0] mag_o,
  output psu_pkg::side_t            side_o
);
  import psu_pkg::*;

  localparam int STEPS = RR_W / 2;

  logic            v_q    [STEPS];
  logic [RR_W-1:0] x_q    [STEPS];
  logic [RR_W-1:0] r_q    [STEPS];
  side_t           side_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam logic [RR_W-1:0] BITV = RR_W'(1) << (RR_W - 2 - 2 * s);
    logic            vin;
    logic [RR_W-1:0] xin, rin, trial, x_d, r_d;
    side_t           sin;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign xin = rr_i;
      assign rin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = v_q[s-1];
      assign xin = x_q[s-1];
      assign rin = r_q[s-1];
      assign sin = side_q[s-1];
    end

    // Try one digit: subtract when the remainder allows it
    always_comb begin
      trial = rin + BITV;
      if (xin >= trial) begin
        x_d = xin - trial;
        r_d = (rin >> 1) + BITV;
      end else begin
        x_d = xin;
        r_d = rin >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= x_d;
        r_q[s]    <= r_d;
        side_q[s] <= sin;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign mag_o   = r_q[STEPS-1][MAG_W-1:0];
  assign side_o  = side_q[STEPS-1];

endmodule

FILE: rtl/psu_div.sv
// Pipelined restoring division V.R / |R| giving the Q.16 cosine, one quotient
// bit per stage, with an overflow flag for quotients beyond the range. Uses psu_pkg.
module psu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [psu_pkg::MAG_W-1:0] mag_i,
  input  psu_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [psu_pkg::Q_W-1:0]   quo_o,
  output logic                      ovf_o,
  output psu_pkg::side_t            side_o
);
  import psu_pkg::*;

  logic             v_q    [Q_W];
  logic [VR_W-1:0]  rem_q  [Q_W];
  logic [MAG_W-1:0] mag_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  logic             ovf_q  [Q_W];
  side_t            side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int B = Q_W - 1 - s;
    logic             vin, oin;
    logic [VR_W-1:0]  rin, trial, rem_d;
    logic [MAG_W-1:0] min_v;
    logic [Q_W-1:0]   qin, quo_d;
    side_t            sin;

    if (s == 0) begin : g_first
      assign vin   = valid_i;
      assign rin   = side_i.vr;
      assign min_v = mag_i;
      assign qin   = '0;
      assign oin   = side_i.vr >= (VR_W'(mag_i) << Q_W);
      assign sin   = side_i;
    end else begin : g_next
      assign vin   = v_q[s-1];
      assign rin   = rem_q[s-1];
      assign min_v = mag_q[s-1];
      assign qin   = quo_q[s-1];
      assign oin   = ovf_q[s-1];
      assign sin   = side_q[s-1];
    end

    // Subtract the shifted divisor when it fits
    always_comb begin
      trial = VR_W'(min_v) << B;
      quo_d = qin;
      if (rin >= trial) begin
        rem_d    = rin - trial;
        quo_d[B] = 1'b1;
      end else begin
        rem_d = rin;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        mag_q[s]  <= min_v;
        quo_q[s]  <= quo_d;
        ovf_q[s]  <= oin;
        side_q[s] <= sin;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign ovf_o   = ovf_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

FILE: rtl/psu_pow.sv
// Specular power: cosine clamp, log2 by repeated squaring, scale by hardness,
// exp2 by a chain of constant root factors, then the specular gain. Uses psu_pkg.
module psu_pow (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [psu_pkg::Q_W-1:0]    quo_i,
  input  logic                       ovf_i,
  input  psu_pkg::side_t             side_i,
  input  logic [15:0]                hardness_i,
  input  logic [15:0]                specular_gain_i,
  output logic                       valid_o,
  output logic [psu_pkg::SPEC_W-1:0] spec_o,
  output psu_pkg::side_t             side_o
);
  import psu_pkg::*;

  // Normalize: clamp the cosine, find its top bit, shift into Q.30
  logic [Q_W-1:0]     cs;
  logic [K_W-1:0]     k_d;
  logic [M_W+Q_W-1:0] sh;
  side_t              sn_d;

  always_comb begin
    cs = (ovf_i || quo_i > Q_W'(CS_ONE)) ? Q_W'(CS_ONE) : quo_i;
    k_d = '0;
    for (int b = 0; b < Q_W; b++) begin
      if (cs[b]) k_d = K_W'(b);
    end
    sh = (M_W+Q_W)'(cs) << (K_W'(M_W - 1) - k_d);
    sn_d = side_i;
    sn_d.spec_ok = side_i.spec_ok && (cs >= Q_W'(CS_MIN));
  end

  logic           vn_q;
  logic [M_W-1:0] mn_q;
  logic [K_W-1:0] kn_q;
  side_t          sn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en_i) begin
      vn_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mn_q <= sh[M_W-1:0];
      kn_q <= k_d;
      sn_q <= sn_d;
    end
  end

  // Log stages: square the mantissa, take one fraction bit each
  logic            vl_q [LOGB];
  logic [M_W-1:0]  ml_q [LOGB];
  logic [K_W-1:0]  kl_q [LOGB];
  logic [LOGB-1:0] fl_q [LOGB];
  side_t           sl_q [LOGB];

  for (genvar s = 0; s < LOGB; s++) begin : g_log
    logic              vin;
    logic [M_W-1:0]    min_v, m_d;
    logic [K_W-1:0]    kin;
    logic [LOGB-1:0]   fin, f_d;
    side_t             sin;
    logic [2*M_W-1:0]  sq;

    if (s == 0) begin : g_first
      assign vin   = vn_q;
      assign min_v = mn_q;
      assign kin   = kn_q;
      assign fin   = '0;
      assign sin   = sn_q;
    end else begin : g_next
      assign vin   = vl_q[s-1];
      assign min_v = ml_q[s-1];
      assign kin   = kl_q[s-1];
      assign fin   = fl_q[s-1];
      assign sin   = sl_q[s-1];
    end

    always_comb begin
      sq  = min_v * min_v;
      f_d = fin;
      if (sq[2*M_W-1]) begin
        m_d = sq[2*M_W-1:M_W];
        f_d[LOGB-1-s] = 1'b1;
      end else begin
        m_d = sq[2*M_W-2:M_W-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[s] <= 1'b0;
      end else if (en_i) begin
        vl_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ml_q[s] <= m_d;
        kl_q[s] <= kin;
        fl_q[s] <= f_d;
        sl_q[s] <= sin;
      end
    end
  end

  // Scale -log2 by hardness, split into integer and fraction
  logic [NEG_W-1:0]    neg;
  logic [NEG_W+15:0]   prod_h;
  logic [NEG_W+7:0]    p8;

  always_comb begin
    neg    = {K_W'(16) - kl_q[LOGB-1], {LOGB{1'b0}}} - NEG_W'(fl_q[LOGB-1]);
    prod_h = neg * hardness_i;
    p8     = prod_h[NEG_W+15:8];
  end

  logic            vp_q;
  logic            zp_q;
  logic [K_W-1:0]  ip_q;
  logic [LOGB-1:0] fp_q;
  side_t           sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= vl_q[LOGB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zp_q <= p8[NEG_W+7:LOGB] > (NEG_W-8)'(16);
      ip_q <= p8[LOGB+K_W-1:LOGB];
      fp_q <= p8[LOGB-1:0];
      sp_q <= sl_q[LOGB-1];
    end
  end

  // Exp stages: multiply in a root factor where the fraction bit is set
  logic            ve_q [LOGB];
  logic [M_W-1:0]  ye_q [LOGB];
  logic            ze_q [LOGB];
  logic [K_W-1:0]  ie_q [LOGB];
  logic [LOGB-1:0] fe_q [LOGB];
  side_t           se_q [LOGB];

  for (genvar s = 0; s < LOGB; s++) begin : g_exp
    localparam logic [29:0] ROOT = exp_root(s + 1);
    logic             vin, zin;
    logic [M_W-1:0]   yin, y_d;
    logic [K_W-1:0]   iin;
    logic [LOGB-1:0]  fin;
    side_t            sin;
    logic [M_W+29:0]  yp;

    if (s == 0) begin : g_first
      assign vin = vp_q;
      assign yin = M_W'(1) << 30;
      assign zin = zp_q;
      assign iin = ip_q;
      assign fin = fp_q;
      assign sin = sp_q;
    end else begin : g_next
      assign vin = ve_q[s-1];
      assign yin = ye_q[s-1];
      assign zin = ze_q[s-1];
      assign iin = ie_q[s-1];
      assign fin = fe_q[s-1];
      assign sin = se_q[s-1];
    end

    always_comb begin
      yp  = yin * ROOT;
      y_d = fin[LOGB-1-s] ? yp[M_W+29:30] : yin;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ve_q[s] <= 1'b0;
      end else if (en_i) begin
        ve_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ye_q[s] <= y_d;
        ze_q[s] <= zin;
        ie_q[s] <= iin;
        fe_q[s] <= fin;
        se_q[s] <= sin;
      end
    end
  end

  // Final shift to Q.16; zero when the term is not applied
  logic [M_W-1:0] y_sh;
  logic           vf_q;
  logic [POW_W-1:0] pow_q;
  side_t          sf_q;

  assign y_sh = ye_q[LOGB-1] >> (6'd14 + 6'(ie_q[LOGB-1]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= ve_q[LOGB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pow_q <= (ze_q[LOGB-1] || !se_q[LOGB-1].spec_ok) ? '0 : y_sh[POW_W-1:0];
      sf_q  <= se_q[LOGB-1];
    end
  end

  // Apply the specular gain
  logic [18+POW_W-1:0] gp;
  logic                vs_q;
  logic [SPEC_W-1:0]   spec_q;
  side_t               ss_q;

  assign gp = {specular_gain_i, 2'b00} * pow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en_i) begin
      vs_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec_q <= gp[SPEC_W+15:16];
      ss_q   <= sf_q;
    end
  end

  assign valid_o = vs_q;
  assign spec_o  = spec_q;
  assign side_o  = ss_q;

endmodule

FILE: rtl/phong_shading_unit_top.sv
// Top level of the Phong shading unit: configuration registers, stream ports,
// colour mixing and the output register. Uses psu_pkg and all psu_* modules.

// One shading query enters per clock while the pipeline advances, and its RGB
// word leaves after 5 geometry stages, 24 square-root stages (one bit of |R|
// each), 17 divider stages (one cosine bit each), 36 power stages (16 squarings
// for log2, 16 root multiplies for exp2, plus clamp, scale, shift and gain) and
// 3 colour stages ending in the output register. The whole pipeline advances
// together; it holds while a finished word waits on m_axis_tready and
// s_axis_tready then drops. Configuration is taken every cycle and must be
// written only while the pipeline is empty.
module phong_shading_unit_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // ray_dir, surface_normal, light_dir, view_dir, object_colour, light_colour
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  // red, green, blue
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import psu_pkg::*;

  // Configuration registers
  logic [15:0] ambient_gain_q, diffuse_gain_q, specular_gain_q, hardness_q;
  logic        full_transmission_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_gain_q      <= '0;
      diffuse_gain_q      <= '0;
      specular_gain_q     <= '0;
      hardness_q          <= 16'd256;
      full_transmission_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_AMBIENT:  ambient_gain_q      <= cfg_data_i;
        CFG_DIFFUSE:  diffuse_gain_q      <= cfg_data_i;
        CFG_SPECULAR: specular_gain_q     <= cfg_data_i;
        CFG_HARDNESS: hardness_q          <= cfg_data_i;
        CFG_TRANSMIT: full_transmission_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the output word is held
  logic adv;
  logic out_v_q;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic             geo_v;
  logic [RR_W-1:0]  geo_rr;
  side_t            geo_side;

  psu_geom u_geom (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .en_i                (adv),
    .valid_i             (s_axis_tvalid),
    .ray_i               (s_axis_tdata[0*FIELD_W +: FIELD_W]),
    .nrm_i               (s_axis_tdata[1*FIELD_W +: FIELD_W]),
    .lgt_i               (s_axis_tdata[2*FIELD_W +: FIELD_W]),
    .view_i              (s_axis_tdata[3*FIELD_W +: FIELD_W]),
    .obj_i               (s_axis_tdata[4*FIELD_W +: FIELD_W]),
    .lc_i                (s_axis_tdata[5*FIELD_W +: FIELD_W]),
    .diffuse_gain_i      (diffuse_gain_q),
    .full_transmission_i (full_transmission_q),
    .valid_o             (geo_v),
    .rr_o                (geo_rr),
    .side_o              (geo_side)
  );

  logic             sq_v;
  logic [MAG_W-1:0] sq_mag;
  side_t            sq_side;

  psu_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (geo_v),
    .rr_i    (geo_rr),
    .side_i  (geo_side),
    .valid_o (sq_v),
    .mag_o   (sq_mag),
    .side_o  (sq_side)
  );

  logic           dv_v;
  logic [Q_W-1:0] dv_quo;
  logic           dv_ovf;
  side_t          dv_side;

  psu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .mag_i   (sq_mag),
    .side_i  (sq_side),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  logic              pw_v;
  logic [SPEC_W-1:0] pw_spec;
  side_t             pw_side;

  psu_pow u_pow (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .valid_i         (dv_v),
    .quo_i           (dv_quo),
    .ovf_i           (dv_ovf),
    .side_i          (dv_side),
    .hardness_i      (hardness_q),
    .specular_gain_i (specular_gain_q),
    .valid_o         (pw_v),
    .spec_o          (pw_spec),
    .side_o          (pw_side)
  );

  // Colour stage 1: object*diffuse, specular*light, object*light
  logic             c1_v_q;
  logic [23:0]      t1_q [3];
  logic [20:0]      t2_q [3];
  logic [19:0]      t3_q [3];
  logic [COL_W-1:0] obj1_q [3];
  logic [COL_W-1:0] lc1_q [3];
  logic             front1_q;
  logic [39:0]      m1 [3];
  logic [36:0]      m2 [3];
  logic [35:0]      m3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1[i] = pw_side.obj[i] * pw_side.diff;
      m2[i] = pw_spec * pw_side.lc[i];
      m3[i] = pw_side.obj[i] * pw_side.lc[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
    end else if (adv) begin
      c1_v_q <= pw_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t1_q[i]   <= m1[i][39:16];
        t2_q[i]   <= m2[i][36:16];
        t3_q[i]   <= m3[i][35:16];
        obj1_q[i] <= pw_side.obj[i];
        lc1_q[i]  <= pw_side.lc[i];
      end
      front1_q <= pw_side.front;
    end
  end

  // Colour stage 2: diffuse and ambient terms times light and gain
  logic             c2_v_q;
  logic [25:0]      u1_q [3];
  logic [21:0]      u3_q [3];
  logic [20:0]      t2b_q [3];
  logic [COL_W-1:0] obj2_q [3];
  logic             front2_q;
  logic [41:0]      n1 [3];
  logic [37:0]      n3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1[i] = t1_q[i] * lc1_q[i];
      n3[i] = t3_q[i] * {ambient_gain_q, 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_v_q <= 1'b0;
    end else if (adv) begin
      c2_v_q <= c1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u1_q[i]   <= n1[i][41:16];
        u3_q[i]   <= n3[i][37:16];
        t2b_q[i]  <= t2_q[i];
        obj2_q[i] <= obj1_q[i];
      end
      front2_q <= front1_q;
    end
  end

  // Colour stage 3: accumulate, drop to Q4.12 and saturate into the output word
  logic [27:0]      acc [3];
  logic [OUT_W-1:0] chan [3];
  logic [47:0]      out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 28'(obj2_q[i]) + 28'(t2b_q[i]) +
               (front2_q ? (28'(u1_q[i]) + 28'(u3_q[i])) : 28'd0);
      chan[i] = (acc[i][27:4+OUT_W] != '0) ? {OUT_W{1'b1}} : acc[i][4+OUT_W-1:4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= c2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {chan[2], chan[1], chan[0]};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: verif/phong_shading_unit_top_test.sv
// Self-checking testbench for phong_shading_unit_top: streams shading queries,
// predicts each RGB word in a scoreboard class, and compares in order.
// Depends on psu_pkg and the rtl of the shading unit only.
module phong_shading_unit_top_test;
  import psu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_QUERIES = 1350;

  // Predicts the shaded color of each query and holds the words still due
  class shade_scoreboard;
    logic [15:0] ambient_gain = 16'd0;
    logic [15:0] diffuse_gain = 16'd0;
    logic [15:0] specular_gain = 16'd0;
    logic [15:0] hardness = 16'd256;
    logic        full_transmission = 1'b0;
    logic [47:0] shade_q[$];
    int          mismatches = 0;
    int          words_checked = 0;
    int          front_hits = 0;
    int          spec_hits = 0;

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_AMBIENT:  ambient_gain = val;
        CFG_DIFFUSE:  diffuse_gain = val;
        CFG_SPECULAR: specular_gain = val;
        CFG_HARDNESS: hardness = val;
        CFG_TRANSMIT: full_transmission = val[0];
        default: ;
      endcase
    endfunction

    function longint comp(logic [47:0] p, int i);
      logic [15:0] c;
      c = p[i*16 +: 16];
      return longint'($signed(c));
    endfunction

    // Shift right with truncation toward zero
    function longint trunc_shr(longint v, int s);
      return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // cos^h for cos in Q.16 and h in Q8.8, result in Q.16
    function longint unsigned cos_power(longint unsigned c, longint unsigned h);
      int k;
      longint unsigned m, frac, neg, p, ip, fp, y, r;
      k = 0;
      frac = 0;
      r = 0;
      while ((c >> (k + 1)) != 0) k++;
      m = c << (30 - k);
      for (int i = 1; i <= 16; i++) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m >>= 1;
          frac |= 64'd1 << (16 - i);
        end
      end
      neg = (longint'(16 - k) << 16) - frac;
      p = (neg * h) >> 8;
      ip = p >> 16;
      fp = p & 64'hFFFF;
      if (ip > 16) return 0;
      y = 64'd1 << 30;
      for (int i = 1; i <= 16; i++) begin
        r = (i == 1) ? int_sqrt(64'd1 << 59) : int_sqrt(r << 30);
        if ((fp >> (16 - i)) & 1) y = (y * r) >> 30;
      end
      return y >> (14 + ip);
    endfunction

    // Specular factor ks * cos^h in Q.16, zero when the term is skipped
    function longint unsigned specular(logic [47:0] nrm, logic [47:0] lgt,
                                       logic [47:0] view, longint nl);
      longint nl16, vr, rr, cs;
      longint rv[3];
      longint unsigned mag;
      nl16 = trunc_shr(nl, 12);
      vr = 0;
      rr = 0;
      for (int i = 0; i < 3; i++)
        rv[i] = trunc_shr(2 * nl16 * (comp(nrm, i) * 4), 16) - comp(lgt, i) * 4;
      for (int i = 0; i < 3; i++) begin
        vr += comp(view, i) * 4 * rv[i];
        rr += rv[i] * rv[i];
      end
      if (rr == 0 || vr <= 0) return 0;
      mag = int_sqrt(rr);
      if (mag == 0) return 0;
      cs = vr / longint'(mag);
      if (cs < 7) return 0;
      if (cs > 65536) cs = 65536;
      spec_hits++;
      return ((longint'(specular_gain) << 2) * cos_power(cs, hardness)) >> 16;
    endfunction

    function void note_query(logic [287:0] d);
      logic [47:0] ray, nrm, lgt, view, objc, lcol, word;
      longint unsigned obj[3], lc[3], acc[3], o;
      longint unsigned spec, diff;
      longint nl, rn;
      ray = d[47:0];
      nrm = d[95:48];
      lgt = d[143:96];
      view = d[191:144];
      objc = d[239:192];
      lcol = d[287:240];
      nl = 0;
      rn = 0;
      spec = 0;
      diff = 0;
      for (int i = 0; i < 3; i++) begin
        nl += comp(nrm, i) * comp(lgt, i);
        rn += comp(ray, i) * comp(nrm, i);
        obj[i] = longint'(objc[i*16 +: 16]) << 2;
        lc[i] = longint'(lcol[i*16 +: 16]) << 2;
        acc[i] = obj[i];
      end
      if (rn < 0) begin
        front_hits++;
        if (diffuse_gain != 0 && nl * 10000 > (64'sd1 <<< 28)) begin
          diff = ((longint'(diffuse_gain) << 2) * longint'(trunc_shr(nl, 12))) >> 16;
          spec = specular(nrm, lgt, view, nl);
        end
        for (int i = 0; i < 3; i++) begin
          acc[i] += (((obj[i] * diff) >> 16) * lc[i]) >> 16;
          acc[i] += (spec * lc[i]) >> 16;
          acc[i] += (((obj[i] * lc[i]) >> 16) * (longint'(ambient_gain) << 2)) >> 16;
        end
      end else if (full_transmission) begin
        spec = specular(nrm, lgt, view, nl);
        for (int i = 0; i < 3; i++) acc[i] += (spec * lc[i]) >> 16;
      end
      for (int i = 0; i < 3; i++) begin
        o = acc[i] >> 4;
        word[i*16 +: 16] = (o > 65535) ? 16'hFFFF : o[15:0];
      end
      shade_q.push_back(word);
    endfunction

    function void check_word(logic [47:0] w);
      logic [47:0] exp_w;
      words_checked++;
      if (shade_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color word %h", w);
        return;
      end
      exp_w = shade_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (w[i*16 +: 16] !== exp_w[i*16 +: 16]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d channel %0d: expected %h, got %h",
                     words_checked, i, exp_w[i*16 +: 16], w[i*16 +: 16]);
        end
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = 3'd0;
  logic [15:0]  cfg_data_i = 16'd0;

  shade_scoreboard sb = new();
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  phong_shading_unit_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Stall the color output at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Note each accepted query and check each accepted color word
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_query(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic real urnd();
    return real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
  endfunction

  // Quantize a direction to Q1.14, scaled to unit length when asked
  function automatic logic [47:0] pack_dir(real x, real y, real z, bit unit);
    real len;
    logic [15:0] c[3];
    len = $sqrt(x * x + y * y + z * z);
    if (!unit || len == 0.0) len = 1.0;
    c[0] = 16'(int'(x / len * 16384.0));
    c[1] = 16'(int'(y / len * 16384.0));
    c[2] = 16'(int'(z / len * 16384.0));
    return {c[2], c[1], c[0]};
  endfunction

  function automatic logic [47:0] rand_color();
    logic [15:0] c[3];
    for (int i = 0; i < 3; i++)
      c[i] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16'h4000));
    return {c[2], c[1], c[0]};
  endfunction

  // Build a plausible hit: unit vectors (the viewer not always), light mostly above the surface
  // and the viewer near the mirror direction
  function automatic logic [287:0] hit_query();
    real nx, ny, nz, lx, ly, lz, d, rx, ry, rz, len, s;
    logic [47:0] ray;
    nx = urnd(); ny = urnd(); nz = urnd();
    len = $sqrt(nx * nx + ny * ny + nz * nz);
    if (len < 0.01) begin nx = 1.0; len = 1.0; end
    nx /= len; ny /= len; nz /= len;
    lx = nx + urnd(); ly = ny + urnd(); lz = nz + urnd();
    len = $sqrt(lx * lx + ly * ly + lz * lz);
    if (len < 0.01) begin lx = nx; ly = ny; lz = nz; len = 1.0; end
    lx /= len; ly /= len; lz /= len;
    d = nx * lx + ny * ly + nz * lz;
    s = 0.3 * real'($urandom_range(0, 3));
    rx = 2.0 * d * nx - lx + s * urnd();
    ry = 2.0 * d * ny - ly + s * urnd();
    rz = 2.0 * d * nz - lz + s * urnd();
    if ($urandom_range(0, 99) < 85)
      ray = pack_dir(-nx + 0.5 * urnd(), -ny + 0.5 * urnd(), -nz + 0.5 * urnd(), 1);
    else
      ray = pack_dir(nx, ny, nz, 1);
    return {rand_color(), rand_color(), pack_dir(rx, ry, rz, $urandom_range(0, 9) != 0),
            pack_dir(lx, ly, lz, 1), pack_dir(nx, ny, nz, 1), ray};
  endfunction

  task automatic send_query(logic [287:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted word has come back; wait for a clock edge first
  // so the last accepted query is already noted
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.shade_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic cfg_all(logic [15:0] amb, logic [15:0] dif, logic [15:0] spc,
                         logic [15:0] hard, logic [15:0] trans);
    cfg_write(CFG_AMBIENT, amb);
    cfg_write(CFG_DIFFUSE, dif);
    cfg_write(CFG_SPECULAR, spc);
    cfg_write(CFG_HARDNESS, hard);
    cfg_write(CFG_TRANSMIT, trans);
  endtask

  initial begin
    logic [47:0] nz, lz, zero, ones, mid;
    logic [15:0] hard;
    int idle_base;
    zero = '0;
    ones = '1;
    mid = {3{16'h4000}};
    idle_base = 0;
    nz = pack_dir(0.0, 0.0, 1.0, 1);
    lz = pack_dir(0.0, 0.6, 0.8, 1);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain reset settings first, then unit gains
    send_query({mid, mid, nz, nz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    drain();
    cfg_all(16'h4000, 16'h4000, 16'h4000, 16'h0100, 16'h0001);
    // head-on light, tilted light, grazing light below the threshold
    send_query({mid, mid, nz, nz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    send_query({mid, mid, pack_dir(0.0, -0.6, 0.8, 1), lz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    send_query({mid, mid, nz, {16'd0, 16'd1, 16'd16384}, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    // viewer away from the reflection, and a non-unit viewer beyond one
    send_query({mid, mid, pack_dir(0.0, 0.6, -0.8, 1), lz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    send_query({mid, mid, {16'h7FFF, 16'h7FFF, 16'h7FFF}, nz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    // back face with transmission: normal reflection and a zero reflected vector
    send_query({mid, mid, nz, nz, nz, nz});
    send_query({mid, mid, nz, zero, nz, nz});
    // extreme fields
    send_query({ones, ones, ones, ones, ones, ones});
    send_query({zero, zero, zero, zero, zero, zero});
    send_query({{3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                {3{16'h8000}}, {3{16'h7FFF}}});
    send_query({{3{16'hFFFF}}, {3{16'hFFFF}}, nz, nz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    drain();
    // saturation with full gains, then zero and huge hardness
    cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFE);
    send_query({{3{16'hFFFF}}, {3{16'hFFFF}}, nz, nz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    send_query({mid, mid, pack_dir(0.0, -0.5, 0.8, 1), lz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    send_query({mid, mid, nz, nz, nz, nz});
    drain();
    cfg_write(CFG_HARDNESS, 16'hFFFF);
    send_query({mid, mid, pack_dir(0.0, -0.5, 0.8, 1), lz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    send_query({mid, mid, nz, nz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    drain();
    // unused register indexes must leave the settings alone
    for (int i = int'(CFG_TRANSMIT) + 1; i < 8; i++) cfg_write(3'(i), 16'hFFFF);
    send_query({mid, mid, nz, nz, nz, pack_dir(0.0, 0.0, -1.0, 1)});
    drain();

    // Random phases with different idling and settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_base = 0; stall_pct = 0; end
        1: begin idle_base = 45; stall_pct = 0; end
        2: begin idle_base = 0; stall_pct = 45; end
        default: begin idle_base = 24; stall_pct = 24; end
      endcase
      for (int part = 0; part < 3; part++) begin
        hard = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 16'h0C00)) : 16'($urandom);
        if (ph == 2 && part == 0)
          cfg_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        else
          cfg_all(16'($urandom), ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom),
                  16'($urandom), hard, 16'($urandom));
        for (int n = 0; n < RANDOM_QUERIES / 12; n++) begin
          // a short spell with no idling inside each part
          send_idle_pct = (n >= RANDOM_QUERIES / 24 && n < RANDOM_QUERIES / 24 + 16) ?
                          0 : idle_base;
          if ($urandom_range(0, 99) < 75)
            send_query(hit_query());
          else
            send_query({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
        end
        drain();
      end
    end

    repeat (100) @(posedge clk_i);
    $display("Checked %0d color words (%0d front hits, %0d specular terms) over",
             sb.words_checked, sb.front_hits, sb.spec_hits);
    $display("directed edge cases and four idling phases; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.shade_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: phong_shading_unit_top.f
rtl/psu_pkg.sv
rtl/psu_geom.sv
rtl/psu_isqrt.sv
rtl/psu_div.sv
rtl/psu_pow.sv
rtl/phong_shading_unit_top.sv
verif/phong_shading_unit_top_test.sv
